>>> rtl/wms_pkg.sv
// ----------------------------------------------------------------------------
// wms_pkg: shared constants for the weighted move score block
// Configuration register indexes, widths and reset values.
// ----------------------------------------------------------------------------
package wms_pkg;

  localparam int TOL_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE = 1'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEASIBLE  = 1'd1;

  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

endpackage

>>> rtl/wms_if.sv
// ----------------------------------------------------------------------------
// wms interfaces: term and result channels
// Valid/ready channels that carry one term word or one result word.
// ----------------------------------------------------------------------------
interface wms_term_if #(
  parameter int VALUE_WIDTH  = 48,
  parameter int WEIGHT_WIDTH = 32
);
  logic                           valid;
  logic                           ready;
  logic                           is_objective;
  logic signed [VALUE_WIDTH-1:0]  row_lhs;
  logic signed [VALUE_WIDTH-1:0]  row_rhs;
  logic        [WEIGHT_WIDTH-1:0] row_weight;
  logic signed [VALUE_WIDTH-1:0]  term_coefficient;
  logic signed [VALUE_WIDTH-1:0]  step_delta;
  logic                           last_term;

  modport source (
    output valid, is_objective, row_lhs, row_rhs, row_weight,
           term_coefficient, step_delta, last_term,
    input  ready
  );
  modport sink (
    input  valid, is_objective, row_lhs, row_rhs, row_weight,
           term_coefficient, step_delta, last_term,
    output ready
  );
endinterface

interface wms_result_if #(
  parameter int VALUE_WIDTH = 48
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] move_score;
  logic signed [VALUE_WIDTH-1:0] move_subscore;

  modport source (output valid, move_score, move_subscore, input ready);
  modport sink   (input  valid, move_score, move_subscore, output ready);
endinterface

>>> rtl/weighted_move_score.sv
// ----------------------------------------------------------------------------
// weighted_move_score: move scoring for a weighted local search
// Scores a candidate change of one variable, one row term per word.
// ----------------------------------------------------------------------------
// Usage: each word on the term channel is one row term of the variable that
// is being moved. The block forms the new left side lhs + coeff*delta, checks
// satisfaction against rhs plus or minus the tolerance, and adds the weighted
// change to two saturating sums. On the word flagged last_term it sends one
// word on the result channel with both sums, and the sums return to zero.
// Throughput: one term per cycle unless the pipeline holds. The 48 by 48
// product is split into four half-width partial products, so the datapath is a
// five-stage pipeline; after stage 5 the result word goes to the output register.
// The user must write the configuration port (tolerance, feasible flag) only
// while no terms are in flight; the block does not enforce this. Reset empties
// the pipeline, clears both sums and loads tolerance 1 and feasible flag 0.
// When the receiver stalls, the result stays in the output register and
// terms keep flowing; the pipeline holds only when the next result is
// ready to leave the last stage while the output register is still full.
// ----------------------------------------------------------------------------
module weighted_move_score #(
  parameter int VALUE_WIDTH  = 48,
  parameter int FRAC_BITS    = 16,
  parameter int WEIGHT_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wms_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [wms_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  wms_term_if.sink                             in,
  wms_result_if.source                         out
);
  import wms_pkg::*;

  localparam int LO_W = VALUE_WIDTH / 2;
  localparam int HI_W = VALUE_WIDTH - LO_W;
  localparam int PW   = 2 * VALUE_WIDTH;
  localparam int NW   = PW + 1;
  localparam int BW   = VALUE_WIDTH + 1;
  localparam int DW   = WEIGHT_WIDTH + 1;
  localparam int AW   = ((VALUE_WIDTH > DW) ? VALUE_WIDTH : DW) + 1;

  // Configuration registers.
  logic [TOL_WIDTH-1:0] tolerance;
  logic                 feasible;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
      feasible  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_TOLERANCE) tolerance <= cfg_data[TOL_WIDTH-1:0];
      if (cfg_index == REG_FEASIBLE)  feasible  <= cfg_data[0];
    end
  end

  // The whole pipeline holds only when a last term would overwrite a result
  // that has not been taken.
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic s5_last;
  logic advance;

  assign advance  = !(s5_valid && s5_last && out.valid && !out.ready);
  assign in.ready = advance;

  // Stage 1: input register.
  logic                           s1_obj, s1_last;
  logic signed [VALUE_WIDTH-1:0]  s1_lhs, s1_rhs, s1_coeff, s1_delta;
  logic        [WEIGHT_WIDTH-1:0] s1_weight;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_obj    <= in.is_objective;
      s1_last   <= in.last_term;
      s1_lhs    <= in.row_lhs;
      s1_rhs    <= in.row_rhs;
      s1_coeff  <= in.term_coefficient;
      s1_delta  <= in.step_delta;
      s1_weight <= in.row_weight;
    end
  end

  // Stage 2: partial products and the tolerance bounds.
  logic        [2*LO_W-1:0]         p_ll_c;
  logic signed [LO_W+HI_W:0]        p_lh_c, p_hl_c;
  logic signed [2*HI_W-1:0]         p_hh_c;
  logic signed [BW-1:0]             tol_s;

  always_comb begin
    p_ll_c = s1_coeff[LO_W-1:0] * s1_delta[LO_W-1:0];
    p_lh_c = $signed({1'b0, s1_coeff[LO_W-1:0]}) * $signed(s1_delta[VALUE_WIDTH-1:LO_W]);
    p_hl_c = $signed(s1_coeff[VALUE_WIDTH-1:LO_W]) * $signed({1'b0, s1_delta[LO_W-1:0]});
    p_hh_c = $signed(s1_coeff[VALUE_WIDTH-1:LO_W]) * $signed(s1_delta[VALUE_WIDTH-1:LO_W]);
    tol_s  = BW'($signed({1'b0, tolerance}));
  end

  logic                           s2_obj, s2_last;
  logic signed [VALUE_WIDTH-1:0]  s2_lhs, s2_rhs;
  logic signed [BW-1:0]           s2_up, s2_dn;
  logic        [WEIGHT_WIDTH-1:0] s2_weight;
  logic        [2*LO_W-1:0]       s2_p_ll;
  logic signed [LO_W+HI_W:0]      s2_p_lh, s2_p_hl;
  logic signed [2*HI_W-1:0]       s2_p_hh;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_obj    <= s1_obj;
      s2_last   <= s1_last;
      s2_lhs    <= s1_lhs;
      s2_rhs    <= s1_rhs;
      s2_up     <= BW'(s1_rhs) + tol_s;
      s2_dn     <= BW'(s1_rhs) - tol_s;
      s2_weight <= s1_weight;
      s2_p_ll   <= p_ll_c;
      s2_p_lh   <= p_lh_c;
      s2_p_hl   <= p_hl_c;
      s2_p_hh   <= p_hh_c;
    end
  end

  // Stage 3: full product, rounded toward minus infinity.
  logic signed [PW-1:0] mid_c, prod_c;

  always_comb begin
    mid_c  = PW'(s2_p_lh) + PW'(s2_p_hl);
    prod_c = (PW'(s2_p_hh) <<< (2 * LO_W)) + (mid_c <<< LO_W)
           + $signed(PW'(s2_p_ll));
  end

  logic                           s3_obj, s3_last;
  logic signed [VALUE_WIDTH-1:0]  s3_lhs, s3_rhs;
  logic signed [BW-1:0]           s3_up, s3_dn;
  logic        [WEIGHT_WIDTH-1:0] s3_weight;
  logic signed [PW-1:0]           s3_prod;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_obj    <= s2_obj;
      s3_last   <= s2_last;
      s3_lhs    <= s2_lhs;
      s3_rhs    <= s2_rhs;
      s3_up     <= s2_up;
      s3_dn     <= s2_dn;
      s3_weight <= s2_weight;
      s3_prod   <= prod_c >>> FRAC_BITS;
    end
  end

  // Stage 4: new left side, exact.
  logic                           s4_obj, s4_last;
  logic signed [VALUE_WIDTH-1:0]  s4_lhs, s4_rhs;
  logic signed [BW-1:0]           s4_up, s4_dn;
  logic        [WEIGHT_WIDTH-1:0] s4_weight;
  logic signed [NW-1:0]           s4_nlhs;

  always_ff @(posedge clk) begin
    if (advance) begin
      s4_obj    <= s3_obj;
      s4_last   <= s3_last;
      s4_lhs    <= s3_lhs;
      s4_rhs    <= s3_rhs;
      s4_up     <= s3_up;
      s4_dn     <= s3_dn;
      s4_weight <= s3_weight;
      s4_nlhs   <= NW'(s3_lhs) + NW'(s3_prod);
    end
  end

  // Stage 5: compares select the score and subscore changes.
  logic signed [NW-1:0] lhs_w, rhs_w, up_w, dn_w;
  logic signed [DW-1:0] w_pos, w_neg, wh_pos, wh_neg;
  logic                 closer, pre_sat, now_sat, pre_st, now_st;
  logic signed [DW-1:0] sc_delta_c, sub_delta_c;

  always_comb begin
    lhs_w   = NW'(s4_lhs);
    rhs_w   = NW'(s4_rhs);
    up_w    = NW'(s4_up);
    dn_w    = NW'(s4_dn);
    w_pos   = $signed({1'b0, s4_weight});
    w_neg   = -w_pos;
    wh_pos  = $signed({2'b00, s4_weight[WEIGHT_WIDTH-1:1]});
    wh_neg  = -wh_pos;
    closer  = s4_nlhs < lhs_w;
    sc_delta_c  = '0;
    sub_delta_c = '0;
    if (s4_obj) begin
      pre_sat = lhs_w < rhs_w;
      now_sat = s4_nlhs < rhs_w;
      pre_st  = 1'b0;
      now_st  = 1'b0;
      if (feasible) begin
        // A change that does not lower the objective counts as worse.
        sc_delta_c = closer ? w_pos : w_neg;
        if (!pre_sat && now_sat)      sub_delta_c = w_pos;
        else if (pre_sat && !now_sat) sub_delta_c = w_neg;
      end
    end else begin
      pre_sat = lhs_w < up_w;
      now_sat = s4_nlhs < up_w;
      pre_st  = lhs_w < dn_w;
      now_st  = s4_nlhs < dn_w;
      if (!pre_sat && now_sat)      sc_delta_c = w_pos;
      else if (pre_sat && !now_sat) sc_delta_c = w_neg;
      else if (!pre_sat)            sc_delta_c = closer ? wh_pos : wh_neg;
      if (!pre_st && now_st)        sub_delta_c = w_pos;
      else if (pre_st && !now_st)   sub_delta_c = w_neg;
    end
  end

  logic signed [DW-1:0] s5_sc_delta, s5_sub_delta;

  always_ff @(posedge clk) begin
    if (advance) begin
      s5_last      <= s4_last;
      s5_sc_delta  <= sc_delta_c;
      s5_sub_delta <= sub_delta_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // Accumulate with saturation to the signed value range.
  logic signed [VALUE_WIDTH-1:0] score_sum, subscore_sum;
  logic signed [VALUE_WIDTH-1:0] score_next, subscore_next;
  logic signed [AW-1:0]          sc_t, sub_t, vmax, vmin;

  always_comb begin
    vmax = AW'($signed({1'b0, {(VALUE_WIDTH-1){1'b1}}}));
    vmin = -vmax - AW'(1);
    sc_t  = AW'(score_sum) + AW'(s5_sc_delta);
    sub_t = AW'(subscore_sum) + AW'(s5_sub_delta);
    if (sc_t > vmax)      score_next = vmax[VALUE_WIDTH-1:0];
    else if (sc_t < vmin) score_next = vmin[VALUE_WIDTH-1:0];
    else                  score_next = sc_t[VALUE_WIDTH-1:0];
    if (sub_t > vmax)      subscore_next = vmax[VALUE_WIDTH-1:0];
    else if (sub_t < vmin) subscore_next = vmin[VALUE_WIDTH-1:0];
    else                   subscore_next = sub_t[VALUE_WIDTH-1:0];
  end

  logic emit;
  assign emit = advance && s5_valid && s5_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_sum    <= '0;
      subscore_sum <= '0;
    end else if (advance && s5_valid) begin
      score_sum    <= s5_last ? '0 : score_next;
      subscore_sum <= s5_last ? '0 : subscore_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (emit) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out.move_score    <= score_next;
      out.move_subscore <= subscore_next;
    end
  end

endmodule

>>> rtl/wms_checker.sv
// ----------------------------------------------------------------------------
// wms_checker: port-level checks for weighted_move_score
// Watches the result channel and the input ready after reset.
// ----------------------------------------------------------------------------
module wms_checker #(
  parameter int VALUE_WIDTH = 48
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_move_score,
  input logic [VALUE_WIDTH-1:0] out_move_subscore
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_move_score) && $stable(out_move_subscore))
    else $error("result changed while stalled");

  // Reset leaves an empty pipeline that takes terms at once.
  assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

  // With the output register empty, terms are never refused.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("terms refused with an empty output register");

endmodule

bind weighted_move_score wms_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_wms_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in.ready),
  .out_valid         (out.valid),
  .out_ready         (out.ready),
  .out_move_score    (out.move_score),
  .out_move_subscore (out.move_subscore)
);

>>> tb/weighted_move_score_tb.sv
// ----------------------------------------------------------------------------
// weighted_move_score_tb: self-checking testbench for weighted_move_score
// Streams row terms through the term channel with random idling on both sides
// but in one steady phase. Each accepted term is scored by a local model of the
// two saturating sums; each result is checked against it or a hand-typed value.
// ----------------------------------------------------------------------------
module weighted_move_score_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wms_pkg::*;

  localparam int VW = 48;
  localparam int FB = 16;
  localparam int WW = 32;
  localparam int LIMIT = 2000;
  localparam int SETTLE = 12;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE = 1 << FB;
  localparam logic [WW-1:0] WMAX = '1;

  typedef struct packed {
    logic                 is_objective;
    logic signed [VW-1:0] lhs;
    logic signed [VW-1:0] rhs;
    logic [WW-1:0]        weight;
    logic signed [VW-1:0] coeff;
    logic signed [VW-1:0] delta;
    logic                 last_term;
  } term_t;

  typedef struct packed {
    logic signed [VW-1:0] score;
    logic signed [VW-1:0] sub;
  } result_t;

  // A row carries a term and, when known is set, the result typed in by hand.
  typedef struct packed {
    term_t                t;
    bit                   known;
    logic signed [VW-1:0] score;
    logic signed [VW-1:0] sub;
  } row_t;

  localparam int N_RESET_ROWS = 16;
  localparam int N_FEAS_ROWS = 7;

  // Default settings: tolerance 1, no feasible solution yet.
  row_t reset_rows [N_RESET_ROWS] = '{
    '{'{1'b0, 0, 0, 100, 0, 0, 1'b1}, 1'b1, 0, 0},
    '{'{1'b1, 5 * ONE, 0, WMAX, ONE, -10 * ONE, 1'b1}, 1'b1, 0, 0},
    '{'{1'b0, 10 * ONE, 0, 8, ONE, -20 * ONE, 1'b1}, 1'b1, 8, 8},
    '{'{1'b0, -10 * ONE, 0, 8, ONE, 20 * ONE, 1'b1}, 1'b1, -8, -8},
    '{'{1'b0, 20 * ONE, 0, 9, ONE, -5 * ONE, 1'b1}, 1'b1, 4, 0},
    '{'{1'b0, 20 * ONE, 0, 9, ONE, 5 * ONE, 1'b1}, 1'b1, -4, 0},
    '{'{1'b0, 0, 0, 6, ONE, 1, 1'b1}, 1'b1, -6, 0},
    '{'{1'b0, 1, 0, 2, 1, -1, 1'b1}, 1'b1, 2, 0},
    '{'{1'b0, -1, 0, 5, 1, -1, 1'b1}, 1'b1, 0, 5},
    '{'{1'b0, 10 * ONE, 0, 0, ONE, -20 * ONE, 1'b1}, 1'b1, 0, 0},
    '{'{1'b0, 10 * ONE, 0, WMAX, ONE, -20 * ONE, 1'b0}, 1'b0, 0, 0},
    '{'{1'b0, 20 * ONE, 0, WMAX, -ONE, 5 * ONE, 1'b0}, 1'b0, 0, 0},
    '{'{1'b0, -ONE, 0, 3, ONE, 2 * ONE, 1'b1}, 1'b0, 0, 0},
    '{'{1'b0, VMAX, VMIN, WMAX, VMAX, VMAX, 1'b1}, 1'b0, 0, 0},
    '{'{1'b0, VMIN, VMAX, WMAX, VMIN, VMIN, 1'b1}, 1'b0, 0, 0},
    '{'{1'b0, VMIN, VMIN, 1, VMIN, VMAX, 1'b1}, 1'b0, 0, 0}
  };

  // Tolerance 0 with the objective enabled.
  row_t feas_rows [N_FEAS_ROWS] = '{
    '{'{1'b1, 5 * ONE, 0, 7, ONE, -10 * ONE, 1'b1}, 1'b1, 7, 7},
    '{'{1'b1, 5 * ONE, 0, 7, ONE, 0, 1'b1}, 1'b1, -7, 0},
    '{'{1'b1, -5 * ONE, 0, 7, ONE, 10 * ONE, 1'b1}, 1'b1, -7, -7},
    '{'{1'b1, -5 * ONE, 0, WMAX, ONE, -ONE, 1'b1}, 1'b1, WMAX, 0},
    '{'{1'b0, 0, 0, 3, 1, -1, 1'b1}, 1'b1, 3, 3},
    '{'{1'b1, VMAX, VMIN, WMAX, VMAX, VMIN, 1'b0}, 1'b0, 0, 0},
    '{'{1'b0, VMAX, 0, WMAX, VMIN, VMIN, 1'b1}, 1'b0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  wms_term_if #(.VALUE_WIDTH(VW), .WEIGHT_WIDTH(WW)) term_ch ();
  wms_result_if #(.VALUE_WIDTH(VW)) result_ch ();

  weighted_move_score #(
    .VALUE_WIDTH(VW),
    .FRAC_BITS(FB),
    .WEIGHT_WIDTH(WW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in(term_ch.sink),
    .out(result_ch.source)
  );

  always #2 clk = ~clk;

  // Local copy of the block state and settings.
  logic signed [VW-1:0] score_acc;
  logic signed [VW-1:0] sub_acc;
  logic [TOL_WIDTH-1:0] tol_reg;
  logic feas_reg;

  result_t pending_scores[$];
  row_t term_rows[$];
  int error_count = 0;
  int idle_cycles = 0;
  bit steady = 1'b0;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] acc,
                                                   input logic signed [127:0] d);
    logic signed [127:0] s;
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    s = acc;
    s = s + d;
    hi = VMAX;
    lo = VMIN;
    if (s > hi) return VMAX;
    if (s < lo) return VMIN;
    return s[VW-1:0];
  endfunction

  // Folds one term into the sums; emit is set on the last term of a move.
  task automatic fold_term(input term_t t, output bit emit, output result_t r);
    logic signed [127:0] lhs, rhs, nlhs, prod, w, wh, tol, up, dn;
    bit psat, nsat, pst, nst;
    lhs = signed'(t.lhs);
    rhs = signed'(t.rhs);
    prod = signed'(t.coeff);
    nlhs = signed'(t.delta);
    prod = (prod * nlhs) >>> FB;
    nlhs = lhs + prod;
    w = {96'd0, t.weight};
    wh = {97'd0, t.weight[WW-1:1]};
    if (t.is_objective) begin
      if (feas_reg) begin
        // An objective step that does not go down counts as worse.
        score_acc = sat_add(score_acc, (nlhs < lhs) ? w : -w);
        psat = lhs < rhs;
        nsat = nlhs < rhs;
        if (!psat && nsat) sub_acc = sat_add(sub_acc, w);
        else if (psat && !nsat) sub_acc = sat_add(sub_acc, -w);
      end
    end else begin
      tol = {112'd0, tol_reg};
      up = rhs + tol;
      dn = rhs - tol;
      psat = lhs < up;
      nsat = nlhs < up;
      pst = lhs < dn;
      nst = nlhs < dn;
      if (!psat && nsat) score_acc = sat_add(score_acc, w);
      else if (psat && !nsat) score_acc = sat_add(score_acc, -w);
      else if (!psat && !nsat) score_acc = sat_add(score_acc, (nlhs < lhs) ? wh : -wh);
      if (!pst && nst) sub_acc = sat_add(sub_acc, w);
      else if (pst && !nst) sub_acc = sat_add(sub_acc, -w);
    end
    emit = t.last_term;
    r.score = score_acc;
    r.sub = sub_acc;
    if (emit) begin
      score_acc = '0;
      sub_acc = '0;
    end
  endtask

  function automatic logic signed [VW-1:0] corner_value();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    case ($urandom_range(0, 6))
      0: return VMIN;
      1: return VMAX;
      2: return 0;
      3: return -1;
      4: return 1;
      5: return ONE;
      default: return bits[VW-1:0];
    endcase
  endfunction

  // Most terms sit close to the row bound so that the new left side crosses
  // the satisfied and stable thresholds often; the rest are wide or corners.
  function automatic term_t random_term(input bit last);
    term_t t;
    int mode, span, off1, off2, c, d;
    bit flip;
    logic [63:0] bits;
    mode = $urandom_range(0, 99);
    span = int'(tol_reg) + 8;
    t.is_objective = ($urandom_range(0, 3) == 0);
    t.weight = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 255);
    t.last_term = last;
    if (mode < 60) begin
      off1 = $urandom_range(0, 4 * span) - 2 * span;
      off2 = $urandom_range(0, 4 * span) - 2 * span;
      t.rhs = signed'($urandom());
      t.lhs = t.rhs + off1;
      if ($urandom_range(0, 4) == 0) begin
        c = $urandom_range(0, 4 * 65536) - 2 * 65536;
        d = $urandom_range(0, 8 * span) - 4 * span;
        t.coeff = c;
        t.delta = d;
      end else begin
        flip = $urandom_range(0, 1);
        d = off2 - off1;
        t.coeff = flip ? -ONE : ONE;
        t.delta = flip ? -d : d;
      end
    end else if (mode < 85) begin
      bits = {$urandom(), $urandom()};
      t.lhs = bits[VW-1:0];
      bits = {$urandom(), $urandom()};
      t.rhs = bits[VW-1:0];
      bits = {$urandom(), $urandom()};
      t.coeff = bits[VW-1:0];
      bits = {$urandom(), $urandom()};
      t.delta = bits[VW-1:0];
    end else begin
      t.lhs = corner_value();
      t.rhs = corner_value();
      t.coeff = corner_value();
      t.delta = corner_value();
      case ($urandom_range(0, 2))
        0: t.weight = WMAX;
        1: t.weight = 0;
        default: t.weight = 1;
      endcase
    end
    return t;
  endfunction

  // Drains term_rows onto the term channel, one word per handshake.
  task automatic send_rows();
    row_t cur;
    bit has;
    bit emit;
    result_t res;
    has = 1'b0;
    while (term_rows.size() > 0 || has) begin
      @(posedge clk);
      if (has && term_ch.ready) begin
        fold_term(cur.t, emit, res);
        if (emit) begin
          if (cur.known) begin
            res.score = cur.score;
            res.sub = cur.sub;
          end
          pending_scores.push_back(res);
        end
        has = 1'b0;
      end
      if (!has && term_rows.size() > 0 && (steady || $urandom_range(0, 99) >= 32)) begin
        cur = term_rows.pop_front();
        term_ch.is_objective <= cur.t.is_objective;
        term_ch.row_lhs <= cur.t.lhs;
        term_ch.row_rhs <= cur.t.rhs;
        term_ch.row_weight <= cur.t.weight;
        term_ch.term_coefficient <= cur.t.coeff;
        term_ch.step_delta <= cur.t.delta;
        term_ch.last_term <= cur.t.last_term;
        term_ch.valid <= 1'b1;
        has = 1'b1;
      end else if (!has) begin
        term_ch.valid <= 1'b0;
      end
    end
  endtask

  // Waits for every result, then lets the pipeline drain any trailing terms.
  task automatic settle();
    while (pending_scores.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == REG_TOLERANCE) tol_reg = val[TOL_WIDTH-1:0];
    else if (idx == REG_FEASIBLE) feas_reg = val[0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result sink with random back-pressure.
  initial begin
    result_t want;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else begin
        if (result_ch.valid && result_ch.ready) begin
          if (pending_scores.size() == 0) begin
            report_mismatch($sformatf("unexpected result score %0d subscore %0d",
                                      result_ch.move_score, result_ch.move_subscore));
          end else begin
            want = pending_scores.pop_front();
            if (result_ch.move_score !== want.score)
              report_mismatch($sformatf("move_score got %0d want %0d",
                                        result_ch.move_score, want.score));
            if (result_ch.move_subscore !== want.sub)
              report_mismatch($sformatf("move_subscore got %0d want %0d",
                                        result_ch.move_subscore, want.sub));
          end
        end
        result_ch.ready <= steady || ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // Ends the run when neither channel has moved a word for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((term_ch.valid && term_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("timeout: no handshake for %0d cycles", LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    row_t row;
    int n, len;
    logic [CFG_DATA_WIDTH-1:0] tol_val;
    logic feas_val;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    term_ch.valid = 1'b0;
    term_ch.is_objective = 1'b0;
    term_ch.row_lhs = '0;
    term_ch.row_rhs = '0;
    term_ch.row_weight = '0;
    term_ch.term_coefficient = '0;
    term_ch.step_delta = '0;
    term_ch.last_term = 1'b0;
    tol_reg = TOL_RESET;
    feas_reg = 1'b0;
    score_acc = '0;
    sub_acc = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (reset_rows[i]) term_rows.push_back(reset_rows[i]);
    send_rows();
    settle();

    write_reg(REG_TOLERANCE, 0);
    write_reg(REG_FEASIBLE, 1);
    foreach (feas_rows[i]) term_rows.push_back(feas_rows[i]);
    send_rows();
    settle();

    row.known = 1'b0;
    row.score = '0;
    row.sub = '0;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin tol_val = 0; feas_val = 1'b0; end
        1: begin tol_val = 16'hFFFF; feas_val = 1'b1; end
        2: begin tol_val = CFG_DATA_WIDTH'($urandom_range(0, 65535)); feas_val = 1'b1; end
        3: begin tol_val = 1; feas_val = 1'b0; end
        4: begin tol_val = CFG_DATA_WIDTH'($urandom_range(0, 16)); feas_val = 1'b1; end
        default: begin
          tol_val = CFG_DATA_WIDTH'($urandom_range(0, 65535));
          feas_val = 1'($urandom_range(0, 1));
        end
      endcase
      write_reg(REG_TOLERANCE, tol_val);
      write_reg(REG_FEASIBLE, {{(CFG_DATA_WIDTH-1){1'b0}}, feas_val});
      steady = (ph == 2);
      n = 0;
      while (n < 152) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          row.t = random_term(k == len - 1);
          term_rows.push_back(row);
        end
        n += len;
      end
      send_rows();
      settle();
    end
    steady = 1'b0;

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> weighted_move_score.f
rtl/wms_pkg.sv
rtl/wms_if.sv
rtl/weighted_move_score.sv
rtl/wms_checker.sv
tb/weighted_move_score_tb.sv
